@@ src/tga_pixel_stream_decoder_core_assert.svh @@
// assertion macros shared by the tga pixel stream decoder modules
`ifndef TGA_PIXEL_STREAM_DECODER_CORE_ASSERT_SVH
`define TGA_PIXEL_STREAM_DECODER_CORE_ASSERT_SVH

// condition holds at every clock edge outside reset
`define TGA_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TGA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/tga_psd_pkg.sv @@
// types and constants of the tga pixel stream decoder
package tga_psd_pkg;

  localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [2:0] CFG_BYTES_PER_PIX = 3'd2;
  localparam logic [2:0] CFG_IMAGE_KIND    = 3'd3;
  localparam logic [2:0] CFG_ROWS_TOP      = 3'd4;
  localparam logic [2:0] CFG_COLS_RTL      = 3'd5;

  localparam logic [1:0] KIND_RAW = 2'd0;
  localparam logic [1:0] KIND_RLE = 2'd1;

  localparam logic [15:0] MIN_WIDTH  = 16'd4;
  localparam logic [2:0]  MAX_DEPTH  = 3'd4;
  localparam int unsigned RUN_FLAG_BIT = 7;
  localparam logic [6:0]  COUNT_MASK = 7'h7f;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_EMIT
  } state_t;

  typedef enum logic {
    PH_HEADER,
    PH_PIXELS
  } phase_t;

  typedef struct packed {
    logic take_byte;
    logic load_total;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic pixel_done;
    logic span_last;
  } status_t;

endpackage

@@ src/tga_psd_datapath.sv @@
// registers, byte decode and span arithmetic of the tga decoder
module tga_psd_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          data_byte,
  input  tga_psd_pkg::cmd_t   cmd,
  output tga_psd_pkg::status_t status,
  output logic [31:0]         pixel_color,
  output logic [15:0]         dest_row,
  output logic [15:0]         first_column,
  output logic [7:0]          span_length,
  output logic                moves_left,
  output logic                last_of_item,
  output logic                image_complete
);

  `include "tga_pixel_stream_decoder_core_assert.svh"

  // configuration
  logic [15:0] width_reg;
  logic [15:0] height_reg;
  logic [2:0]  depth_reg;
  logic [1:0]  kind_reg;
  logic        top_first;
  logic        right_to_left;

  // packet parsing
  tga_psd_pkg::phase_t phase;
  logic [1:0]  slot;
  logic [31:0] assembly;
  logic [7:0]  packet_left;
  logic        packet_run;

  // stream position
  logic [15:0] col;
  logic [15:0] row;
  logic [31:0] pixels_left;
  logic        done;

  // pending span source
  logic [31:0] color;
  logic [7:0]  run_left;

  logic [15:0] eff_width;
  logic [2:0]  eff_depth;
  logic        cfg_hit;
  logic        ignore_byte;
  logic        is_header;
  logic [31:0] asm_next;
  logic [2:0]  slot_inc;
  logic        pix_end;

  logic [15:0] avail;
  logic [7:0]  len_a;
  logic [7:0]  len;
  logic [16:0] col_sum;
  logic        wrap;
  logic [31:0] pixels_after;
  logic        done_after;
  logic [15:0] row_out;
  logic [15:0] col_out;

  always_comb begin
    eff_width = (width_reg < tga_psd_pkg::MIN_WIDTH) ? tga_psd_pkg::MIN_WIDTH : width_reg;
    if (depth_reg == 3'd0) begin
      eff_depth = 3'd1;
    end else if (depth_reg > tga_psd_pkg::MAX_DEPTH) begin
      eff_depth = tga_psd_pkg::MAX_DEPTH;
    end else begin
      eff_depth = depth_reg;
    end
    cfg_hit     = cfg_we && (cfg_index <= tga_psd_pkg::CFG_COLS_RTL);
    ignore_byte = done || kind_reg[1];
    is_header   = (kind_reg == tga_psd_pkg::KIND_RLE) && (phase == tga_psd_pkg::PH_HEADER);
    asm_next    = assembly | ({24'd0, data_byte} << {slot, 3'b000});
    slot_inc    = {1'b0, slot} + 3'd1;
    pix_end     = slot_inc >= eff_depth;

    // span clipped at row end and at image end
    avail        = eff_width - col;
    len_a        = ({8'd0, run_left} < avail) ? run_left : avail[7:0];
    len          = ({24'd0, len_a} > pixels_left) ? pixels_left[7:0] : len_a;
    col_sum      = {1'b0, col} + {9'd0, len};
    wrap         = col_sum >= {1'b0, eff_width};
    pixels_after = pixels_left - {24'd0, len};
    done_after   = pixels_after == 32'd0;
    row_out      = top_first ? row : height_reg - 16'd1 - row;
    col_out      = right_to_left ? eff_width - 16'd1 - col : col;

    status.cfg_hit    = cfg_hit;
    status.pixel_done = !ignore_byte && !is_header && pix_end;
    status.span_last  = (len == run_left) || done_after;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg     <= tga_psd_pkg::MIN_WIDTH;
      height_reg    <= 16'd1;
      depth_reg     <= 3'd3;
      kind_reg      <= tga_psd_pkg::KIND_RAW;
      top_first     <= 1'b0;
      right_to_left <= 1'b0;
      phase         <= tga_psd_pkg::PH_HEADER;
      slot          <= 2'd0;
      assembly      <= 32'd0;
      packet_left   <= 8'd0;
      packet_run    <= 1'b0;
      col           <= 16'd0;
      row           <= 16'd0;
      pixels_left   <= 32'd4;
      done          <= 1'b0;
      run_left      <= 8'd0;
    end else if (cfg_hit) begin
      case (cfg_index)
        tga_psd_pkg::CFG_IMAGE_WIDTH:   width_reg     <= cfg_data;
        tga_psd_pkg::CFG_IMAGE_HEIGHT:  height_reg    <= cfg_data;
        tga_psd_pkg::CFG_BYTES_PER_PIX: depth_reg     <= cfg_data[2:0];
        tga_psd_pkg::CFG_IMAGE_KIND:    kind_reg      <= cfg_data[1:0];
        tga_psd_pkg::CFG_ROWS_TOP:      top_first     <= cfg_data[0];
        tga_psd_pkg::CFG_COLS_RTL:      right_to_left <= cfg_data[0];
        default: ;
      endcase
      // restart; pixel total follows in the load cycle
      phase       <= tga_psd_pkg::PH_HEADER;
      slot        <= 2'd0;
      assembly    <= 32'd0;
      packet_left <= 8'd0;
      packet_run  <= 1'b0;
      col         <= 16'd0;
      row         <= 16'd0;
      run_left    <= 8'd0;
    end else if (cmd.load_total) begin
      pixels_left <= {16'd0, eff_width} * {16'd0, height_reg};
      done        <= height_reg == 16'd0;
    end else if (cmd.take_byte && !ignore_byte) begin
      if (is_header) begin
        packet_left <= {1'b0, data_byte[6:0] & tga_psd_pkg::COUNT_MASK} + 8'd1;
        packet_run  <= data_byte[tga_psd_pkg::RUN_FLAG_BIT];
        phase       <= tga_psd_pkg::PH_PIXELS;
        slot        <= 2'd0;
        assembly    <= 32'd0;
      end else if (pix_end) begin
        slot     <= 2'd0;
        assembly <= 32'd0;
        color    <= asm_next;
        if (kind_reg == tga_psd_pkg::KIND_RAW) begin
          run_left <= 8'd1;
        end else if (packet_run) begin
          run_left    <= packet_left;
          packet_left <= 8'd0;
          phase       <= tga_psd_pkg::PH_HEADER;
        end else begin
          run_left    <= 8'd1;
          packet_left <= packet_left - 8'd1;
          if (packet_left == 8'd1) begin
            phase <= tga_psd_pkg::PH_HEADER;
          end
        end
      end else begin
        slot     <= slot_inc[1:0];
        assembly <= asm_next;
      end
    end else if (cmd.emit) begin
      col         <= wrap ? 16'd0 : col_sum[15:0];
      row         <= wrap ? row + 16'd1 : row;
      pixels_left <= pixels_after;
      done        <= done_after;
      run_left    <= run_left - len;
    end
  end

  // output register of the span channel
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_color    <= color;
      dest_row       <= row_out;
      first_column   <= col_out;
      span_length    <= len;
      moves_left     <= right_to_left;
      last_of_item   <= status.span_last;
      image_complete <= done_after;
    end
  end

  `TGA_ASSERT_ALWAYS(a_span_len_nonzero, !cmd.emit || len != 8'd0,
    "span emitted with zero length")

endmodule

@@ src/tga_psd_ctrl.sv @@
// control state machine of the tga decoder: byte intake, total load, span emission
module tga_psd_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 data_valid,
  output logic                 data_stall,
  output logic                 span_valid,
  input  logic                 span_stall,
  input  tga_psd_pkg::status_t status,
  output tga_psd_pkg::cmd_t    cmd
);

  `include "tga_pixel_stream_decoder_core_assert.svh"

  tga_psd_pkg::state_t state;
  tga_psd_pkg::state_t state_next;
  logic                span_valid_next;
  logic                in_accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= tga_psd_pkg::ST_IDLE;
      span_valid <= 1'b0;
    end else begin
      state      <= state_next;
      span_valid <= span_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    data_stall     = 1'b1;
    in_accept      = 1'b0;
    case (state)
      tga_psd_pkg::ST_IDLE: begin
        data_stall    = status.cfg_hit;
        in_accept     = data_valid && !status.cfg_hit;
        cmd.take_byte = in_accept;
        if (in_accept && status.pixel_done) begin
          state_next = tga_psd_pkg::ST_EMIT;
        end
      end
      tga_psd_pkg::ST_LOAD: begin
        cmd.load_total = 1'b1;
        state_next     = tga_psd_pkg::ST_IDLE;
      end
      tga_psd_pkg::ST_EMIT: begin
        // output register free or being taken this cycle
        cmd.emit = !span_valid || !span_stall;
        if (cmd.emit && status.span_last) begin
          state_next = tga_psd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tga_psd_pkg::ST_IDLE;
      end
    endcase
    if (status.cfg_hit) begin
      cmd.emit   = 1'b0;
      state_next = tga_psd_pkg::ST_LOAD;
    end
    span_valid_next = cmd.emit || (span_valid && span_stall);
  end

  `TGA_ASSERT_ALWAYS(a_accept_only_idle,
    !(data_valid && !data_stall) || state == tga_psd_pkg::ST_IDLE,
    "byte transaction accepted outside idle")
  `TGA_ASSERT_ALWAYS(a_no_overwrite,
    !(cmd.emit && span_valid && span_stall),
    "held span overwritten while stalled")
  `TGA_ASSERT_NEXT(a_last_span_idle,
    state == tga_psd_pkg::ST_EMIT && cmd.emit && status.span_last && !status.cfg_hit,
    state == tga_psd_pkg::ST_IDLE,
    "controller stayed in emit after last span")

endmodule

@@ src/tga_pixel_stream_decoder_core.sv @@
// tga pixel stream decoder: top level joining controller and datapath
// a byte that completes no pixel is taken while the controller is idle; input is held off otherwise
// a byte that completes a pixel is followed by n spans (1..33), one span per cycle while the output is not stalled
// after its byte transaction the first span is computed in the emit state and then held in the output register
// a configuration write stalls input in its own cycle and in the load state, while the total is loaded
// synchronous reset restores register defaults (4x1, 3 bytes, raw) and restarts decoding
module tga_pixel_stream_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  output logic        span_valid,
  input  logic        span_stall,
  output logic [31:0] pixel_color,
  output logic [15:0] dest_row,
  output logic [15:0] first_column,
  output logic [7:0]  span_length,
  output logic        moves_left,
  output logic        last_of_item,
  output logic        image_complete
);

  tga_psd_pkg::cmd_t    cmd;
  tga_psd_pkg::status_t status;

  tga_psd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .span_valid (span_valid),
    .span_stall (span_stall),
    .status     (status),
    .cmd        (cmd)
  );

  tga_psd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .data_byte      (data_byte),
    .cmd            (cmd),
    .status         (status),
    .pixel_color    (pixel_color),
    .dest_row       (dest_row),
    .first_column   (first_column),
    .span_length    (span_length),
    .moves_left     (moves_left),
    .last_of_item   (last_of_item),
    .image_complete (image_complete)
  );

endmodule

@@ tb/tb_tga_pixel_stream_decoder_core.sv @@
// testbench for the tga pixel stream decoder core: byte driver, span monitor, span predictor
module tb_tga_pixel_stream_decoder_core;

  localparam logic [2:0] CFG_UNUSED       = 3'd7;
  localparam logic [1:0] KIND_UNSUPPORTED = 2'd2;
  localparam logic [1:0] KIND_RESERVED    = 2'd3;
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TARGET_BYTES   = 410;

  typedef struct packed {
    logic [31:0] color;
    logic [15:0] row;
    logic [15:0] col;
    logic [7:0]  len;
    logic        left;
    logic        last;
    logic        complete;
  } span_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = '0;
  logic        span_valid;
  logic        span_stall = 1'b0;
  logic [31:0] pixel_color;
  logic [15:0] dest_row;
  logic [15:0] first_column;
  logic [7:0]  span_length;
  logic        moves_left;
  logic        last_of_item;
  logic        image_complete;

  // decoder registers as the predictor sees them
  logic [15:0] cfg_width, cfg_height;
  logic [2:0]  cfg_bpp;
  logic [1:0]  cfg_kind;
  logic        cfg_top, cfg_rtl;

  // predictor state
  tga_psd_pkg::phase_t dec_phase;
  int unsigned pix_slot;
  logic [31:0] pix_assembly;
  logic [7:0]  pkt_left;
  logic        pkt_run;
  logic [15:0] str_col, str_row;
  logic [31:0] pix_left;
  logic        img_done;

  logic [7:0]  pending_bytes[$];
  span_t       expected_spans[$];
  span_t       want_span;
  int          failures = 0;
  int          bytes_planned = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;
  bit          drv_free;
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;

  tga_pixel_stream_decoder_core DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .data_valid     (data_valid),
    .data_stall     (data_stall),
    .data_byte      (data_byte),
    .span_valid     (span_valid),
    .span_stall     (span_stall),
    .pixel_color    (pixel_color),
    .dest_row       (dest_row),
    .first_column   (first_column),
    .span_length    (span_length),
    .moves_left     (moves_left),
    .last_of_item   (last_of_item),
    .image_complete (image_complete)
  );

  always #1 clk = ~clk;

  function automatic int unsigned eff_width();
    return (cfg_width < tga_psd_pkg::MIN_WIDTH) ? 32'(tga_psd_pkg::MIN_WIDTH)
                                                : 32'(cfg_width);
  endfunction

  function automatic int unsigned eff_depth();
    if (cfg_bpp == 3'd0) return 1;
    return (cfg_bpp > tga_psd_pkg::MAX_DEPTH) ? 32'(tga_psd_pkg::MAX_DEPTH) : 32'(cfg_bpp);
  endfunction

  function automatic void restart_image();
    dec_phase    = tga_psd_pkg::PH_HEADER;
    pix_slot     = 0;
    pix_assembly = '0;
    pkt_left     = '0;
    pkt_run      = 1'b0;
    str_col      = '0;
    str_row      = '0;
    pix_left     = eff_width() * 32'(cfg_height);
    img_done     = (pix_left == 32'd0);
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [15:0] val);
    case (idx)
      tga_psd_pkg::CFG_IMAGE_WIDTH:   cfg_width  = val;
      tga_psd_pkg::CFG_IMAGE_HEIGHT:  cfg_height = val;
      tga_psd_pkg::CFG_BYTES_PER_PIX: cfg_bpp    = val[2:0];
      tga_psd_pkg::CFG_IMAGE_KIND:    cfg_kind   = val[1:0];
      tga_psd_pkg::CFG_ROWS_TOP:      cfg_top    = val[0];
      tga_psd_pkg::CFG_COLS_RTL:      cfg_rtl    = val[0];
      default:                        return;
    endcase
    restart_image();
  endfunction

  // lays n pixels of one colour along the stream, splitting at row ends and clipping at the end
  function automatic int place_pixels(logic [31:0] color, int unsigned n);
    int unsigned w, avail, len;
    int          k;
    span_t       s;
    w = eff_width();
    k = 0;
    while (n > 0 && !img_done) begin
      avail = w - 32'(str_col);
      len = (n < avail) ? n : avail;
      if (len > pix_left) len = pix_left;
      s.color = color;
      s.row   = cfg_top ? str_row : cfg_height - 16'd1 - str_row;
      s.col   = cfg_rtl ? 16'(w - 32'd1 - 32'(str_col)) : str_col;
      s.len   = 8'(len);
      s.left  = cfg_rtl;
      s.last  = 1'b0;
      str_col  = 16'(32'(str_col) + len);
      n        = n - len;
      pix_left = pix_left - len;
      if (32'(str_col) >= w) begin
        str_col = '0;
        str_row = str_row + 16'd1;
      end
      if (pix_left == 32'd0) img_done = 1'b1;
      s.complete = img_done;
      expected_spans.push_back(s);
      k++;
    end
    return k;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    logic [31:0] color;
    int          k;
    span_t       s;
    if (img_done || cfg_kind > tga_psd_pkg::KIND_RLE) return;
    if (cfg_kind == tga_psd_pkg::KIND_RLE && dec_phase == tga_psd_pkg::PH_HEADER) begin
      pkt_left     = {1'b0, b[6:0] & tga_psd_pkg::COUNT_MASK} + 8'd1;
      pkt_run      = b[tga_psd_pkg::RUN_FLAG_BIT];
      dec_phase    = tga_psd_pkg::PH_PIXELS;
      pix_slot     = 0;
      pix_assembly = '0;
      return;
    end
    pix_assembly = pix_assembly | (32'(b) << (8 * (pix_slot & 3)));
    pix_slot++;
    if (pix_slot < eff_depth()) return;
    color        = pix_assembly;
    pix_slot     = 0;
    pix_assembly = '0;
    if (cfg_kind == tga_psd_pkg::KIND_RAW) begin
      k = place_pixels(color, 1);
    end else if (pkt_run) begin
      k = place_pixels(color, 32'(pkt_left));
      pkt_left  = '0;
      dec_phase = tga_psd_pkg::PH_HEADER;
    end else begin
      k = place_pixels(color, 1);
      pkt_left = pkt_left - 8'd1;
      if (pkt_left == 8'd0) dec_phase = tga_psd_pkg::PH_HEADER;
    end
    if (k > 0) begin
      s = expected_spans.pop_back();
      s.last = 1'b1;
      expected_spans.push_back(s);
    end
  endfunction

  // byte driver
  always @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      gap_left = 0;
    end else begin
      drv_free = !data_valid;
      if (data_valid && !data_stall) begin
        decode_byte(data_byte);
        drv_free = 1'b1;
      end
      if (drv_free) begin
        if (gap_left != 0) begin
          gap_left--;
          data_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          data_byte  <= pending_bytes.pop_front();
          data_valid <= 1'b1;
          gap_left = send_idle ? $urandom_range(0, 7) : 0;
        end else begin
          data_valid <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      failures++;
    end
  endtask

  // span monitor
  always @(posedge clk) begin
    if (rst) begin
      span_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (span_valid && !span_stall) begin
        if (expected_spans.size() == 0) begin
          $display("%0t: unexpected span, expected none, actual colour %0h row %0d col %0d",
                   $time, pixel_color, dest_row, first_column);
          failures++;
        end else begin
          want_span = expected_spans.pop_front();
          compare_field("pixel_color", want_span.color, pixel_color);
          compare_field("dest_row", 32'(want_span.row), 32'(dest_row));
          compare_field("first_column", 32'(want_span.col), 32'(first_column));
          compare_field("span_length", 32'(want_span.len), 32'(span_length));
          compare_field("moves_left", 32'(want_span.left), 32'(moves_left));
          compare_field("last_of_item", 32'(want_span.last), 32'(last_of_item));
          compare_field("image_complete", 32'(want_span.complete), 32'(image_complete));
        end
        hold_left = recv_idle ? $urandom_range(0, 7) : 0;
      end else if (hold_left != 0) begin
        hold_left--;
      end
      span_stall <= (hold_left != 0);
    end
  end

  // watchdog on cycles with no transaction on any port
  always @(posedge clk) begin
    if (rst || (data_valid && !data_stall) || (span_valid && !span_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_byte(logic [7:0] b);
    pending_bytes.push_back(b);
    bytes_planned++;
  endtask

  // wait until every byte is taken and every span seen, then let the core go quiet
  task automatic settle_block();
    @(negedge clk);
    while (pending_bytes.size() != 0 || data_valid || expected_spans.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, val);
    @(negedge clk);
  endtask

  // writes all six registers in shuffled order, junk in the unused upper bits
  task automatic setup_image(logic [15:0] w, logic [15:0] h, logic [2:0] bpp,
                             logic [1:0] kind, logic top, logic rtl);
    logic [2:0]  order [0:5];
    logic [15:0] vals [0:5];
    logic [2:0]  t;
    int          i, j;
    vals[tga_psd_pkg::CFG_IMAGE_WIDTH]   = w;
    vals[tga_psd_pkg::CFG_IMAGE_HEIGHT]  = h;
    vals[tga_psd_pkg::CFG_BYTES_PER_PIX] = {13'($urandom), bpp};
    vals[tga_psd_pkg::CFG_IMAGE_KIND]    = {14'($urandom), kind};
    vals[tga_psd_pkg::CFG_ROWS_TOP]      = {15'($urandom), top};
    vals[tga_psd_pkg::CFG_COLS_RTL]      = {15'($urandom), rtl};
    for (i = 0; i < 6; i++) order[i] = 3'(i);
    for (i = 5; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    for (i = 0; i < 6; i++) write_register(order[i], vals[order[i]]);
  endtask

  // a write to a missing register must not restart the image
  task automatic maybe_poke_unused();
    if ($urandom_range(0, 15) == 0) begin
      settle_block();
      write_register(CFG_UNUSED, 16'($urandom));
    end
  endtask

  task automatic plan_rle(int unsigned target, int unsigned depth);
    int unsigned placed, cnt, i;
    logic        run;
    placed = 0;
    while (placed < target && bytes_planned < TARGET_BYTES) begin
      maybe_poke_unused();
      run = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       cnt = 127;
        1:       cnt = $urandom_range(0, 127);
        default: cnt = $urandom_range(0, 7);
      endcase
      if (!run) cnt = cnt & 7;
      push_byte({run, 7'(cnt)});
      for (i = 0; i < (run ? 1 : cnt + 1) * depth; i++) push_byte(8'($urandom));
      placed += cnt + 1;
    end
    // occasionally leave a packet cut short
    if ($urandom_range(0, 3) == 0) begin
      push_byte(8'($urandom));
      repeat ($urandom_range(0, depth - 1)) push_byte(8'($urandom));
    end
  endtask

  task automatic run_random_image();
    logic [15:0] w, h;
    logic [2:0]  bpp;
    logic [1:0]  kind;
    int unsigned r, target, i;
    send_idle = ($urandom_range(0, 2) != 0);
    recv_idle = ($urandom_range(0, 2) != 0);
    r = $urandom_range(0, 19);
    w = (r < 3) ? 16'($urandom_range(0, 3)) : (r < 5) ? 16'($urandom)
                                                    : 16'($urandom_range(4, 8));
    r = $urandom_range(0, 19);
    h = (r < 2) ? 16'd0 : (r < 4) ? 16'($urandom) : 16'($urandom_range(1, 4));
    bpp = ($urandom_range(0, 5) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4));
    r = $urandom_range(0, 19);
    kind = (r == 0) ? KIND_UNSUPPORTED : (r == 1) ? KIND_RESERVED
                                       : (r < 8) ? tga_psd_pkg::KIND_RAW
                                                 : tga_psd_pkg::KIND_RLE;
    settle_block();
    setup_image(w, h, bpp, kind, 1'($urandom), 1'($urandom));
    if (kind > tga_psd_pkg::KIND_RLE || pix_left == 32'd0) begin
      // every byte is dropped here
      repeat (4) push_byte(8'($urandom));
    end else if (kind == tga_psd_pkg::KIND_RAW) begin
      target = (pix_left < 24) ? pix_left : 24;
      for (i = 0; i < target && bytes_planned < TARGET_BYTES; i++) begin
        maybe_poke_unused();
        repeat (eff_depth()) push_byte(8'($urandom));
      end
      push_byte(8'($urandom));
    end else begin
      plan_rle((pix_left < 64) ? pix_left : 64, eff_depth());
    end
  endtask

  initial begin
    cfg_width  = 16'd4;
    cfg_height = 16'd1;
    cfg_bpp    = 3'd3;
    cfg_kind   = tga_psd_pkg::KIND_RAW;
    cfg_top    = 1'b0;
    cfg_rtl    = 1'b0;
    restart_image();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults straight out of reset
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h80);
    push_byte(8'h7F); push_byte(8'h01); push_byte(8'hFE);

    // width below four, zero depth, longest run clipped at image end, trailing byte dropped
    settle_block();
    setup_image(16'd0, 16'd3, 3'd0, tga_psd_pkg::KIND_RLE, 1'b1, 1'b1);
    push_byte(8'hFF); push_byte(8'hA5); push_byte(8'h00);

    // literal packet then a run that wraps onto the next row
    settle_block();
    setup_image(16'd5, 16'd2, 3'd2, tga_psd_pkg::KIND_RLE, 1'b0, 1'b0);
    push_byte(8'h01); push_byte(8'h34); push_byte(8'h12); push_byte(8'h78);
    push_byte(8'h56); push_byte(8'h83); push_byte(8'h00); push_byte(8'hFF);

    settle_block();
    setup_image(16'd4, 16'd1, 3'd1, KIND_UNSUPPORTED, 1'b0, 1'b0);
    push_byte(8'h11); push_byte(8'h22);

    // zero height means nothing to draw
    settle_block();
    setup_image(16'd4, 16'd0, 3'd1, tga_psd_pkg::KIND_RAW, 1'b0, 1'b0);
    push_byte(8'h33); push_byte(8'h44);

    // oversized depth, pixel assembled across a write to a missing register
    settle_block();
    setup_image(16'd4, 16'd2, 3'd7, tga_psd_pkg::KIND_RAW, 1'b0, 1'b1);
    push_byte(8'h01); push_byte(8'h02);
    settle_block();
    write_register(CFG_UNUSED, 16'hFFFF);
    push_byte(8'h03); push_byte(8'h04);

    // largest image
    settle_block();
    setup_image(16'hFFFF, 16'hFFFF, 3'd1, tga_psd_pkg::KIND_RAW, 1'b0, 1'b1);
    push_byte(8'hC3); push_byte(8'h3C);

    while (bytes_planned < TARGET_BYTES) run_random_image();

    settle_block();
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
